// ===== rtl/core/btwfp_pkg.sv =====
// package: types, phase codes and status codes for the block/tx wire format parser
package btwfp_pkg;

  localparam int unsigned HashBytes = 32;
  localparam int unsigned CountBits = 32;

  localparam logic [7:0]  TagU16     = 8'd253;
  localparam logic [7:0]  TagU32     = 8'd254;
  localparam logic [63:0] MinU32Form = 64'h1_0000;
  localparam logic [63:0] MinU64Form = 64'h1_0000_0000;
  localparam logic [63:0] MaxSize    = 64'd4000000;
  localparam logic [63:0] CountMax   = 64'(64'hFFFF_FFFF >> (32 - CountBits));
  localparam logic [7:0]  SegwitFlag = 8'd1;

  localparam logic [1:0] ModeBlock  = 2'd0;
  localparam logic [1:0] ModeHeader = 2'd1;

  localparam logic [4:0] KindIgnored = 5'd21;

  typedef enum logic [4:0] {
    PH_BVER, PH_PREV, PH_MERKLE, PH_TIME, PH_BITS, PH_NONCE, PH_TXCOUNT, PH_TXVER,
    PH_INCOUNT, PH_FLAG, PH_HASH, PH_INDEX, PH_ISCRLEN, PH_ISCR, PH_SEQ,
    PH_OUTCOUNT, PH_AMOUNT, PH_OSCRLEN, PH_OSCR, PH_WCOUNT, PH_WLEN, PH_WBYTE,
    PH_LOCK, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK, ST_ACCEPTED, ST_TRUNCATED, ST_NONCANON, ST_LIMIT, ST_BADFLAG,
    ST_NOWITNESS, ST_TRAILING
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  field_kind;
    logic [4:0]  field_byte_index;
    logic [63:0] field_value;
    logic        field_complete;
    logic [2:0]  status;
    logic        message_end;
  } out_beat_t;

  function automatic logic [4:0] kind_of_phase(phase_e ph);
    case (ph)
      PH_OSCRLEN: kind_of_phase = 5'd12;
      PH_OSCR:    kind_of_phase = 5'd13;
      PH_WCOUNT:  kind_of_phase = 5'd17;
      PH_WLEN:    kind_of_phase = 5'd18;
      PH_WBYTE:   kind_of_phase = 5'd19;
      PH_LOCK:    kind_of_phase = 5'd20;
      PH_DONE:    kind_of_phase = KindIgnored;
      default:    kind_of_phase = 5'(ph);
    endcase
  endfunction

endpackage

// ===== rtl/core/btwfp_cfg.sv =====
// apb configuration register: message mode
module btwfp_cfg import btwfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  mode_o,
  output logic        restart_o
);
  logic [1:0] mode_q, mode_d;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign restart_o = wr && (paddr == 2'd0);
  assign mode_d = restart_o ? pwdata[1:0] : mode_q;
  assign prdata = (paddr == 2'd0) ? {30'd0, mode_q} : 32'd0;
  // restart takes the mode being written
  assign mode_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeBlock;
    end else begin
      mode_q <= mode_d;
    end
  end
endmodule

// ===== rtl/core/btwfp_core.sv =====
// parse state and per-beat classification of message bytes
module btwfp_core import btwfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] mode_i,
  input  logic      restart_i,
  input  logic      step_i,
  input  in_beat_t  beat_i,
  output out_beat_t beat_o
);
  phase_e      ph_q, ph_d;
  logic [5:0]  bif_q, bif_d;
  logic [63:0] acc_q, acc_d;
  logic [7:0]  tag_q, tag_d;
  logic [CountBits-1:0] txr_q, txr_d, inr_q, inr_d, intot_q, intot_d;
  logic [CountBits-1:0] outr_q, outr_d, scr_q, scr_d, wir_q, wir_d;
  logic        sw_q, sw_d, aw_q, aw_d, done_q, done_d;
  status_e     st_q, st_d;

  logic [7:0]  b;
  logic [63:0] val, sval;
  logic [CountBits-1:0] c;
  logic        comp, sdone, adv, is_tx;
  logic [2:0]  need;
  logic [5:0]  bif1;
  logic [CountBits-1:0] inr_dec, outr_dec, wir_dec, scr_dec;
  status_e     fst;
  phase_e      first_ph;

  assign b = beat_i.data_byte;
  assign is_tx = mode_i[1];
  assign first_ph = is_tx ? PH_TXVER : PH_BVER;
  assign bif1 = bif_q - 6'd1;
  assign need = (tag_q == TagU16) ? 3'd2 : (tag_q == TagU32) ? 3'd4 : 3'd0;
  assign inr_dec = inr_q - 1'b1;
  assign outr_dec = outr_q - 1'b1;
  assign wir_dec = wir_q - 1'b1;
  assign scr_dec = scr_q - 1'b1;

  always_comb begin
    ph_d = ph_q; bif_d = bif_q; acc_d = acc_q; tag_d = tag_q;
    txr_d = txr_q; inr_d = inr_q; intot_d = intot_q; outr_d = outr_q;
    scr_d = scr_q; wir_d = wir_q; sw_d = sw_q; aw_d = aw_q; done_d = done_q;
    st_d = st_q;
    val = '0; comp = 1'b0; adv = 1'b0; sdone = 1'b0; sval = '0; c = '0;
    beat_o.field_kind = KindIgnored;
    beat_o.field_byte_index = '0;
    if (st_q != ST_OK) begin
    end else if (ph_q == PH_DONE) begin
      st_d = ST_TRAILING;
    end else begin
      beat_o.field_kind = kind_of_phase(ph_q);
      beat_o.field_byte_index = bif_q[4:0];
      case (ph_q)
        PH_PREV, PH_MERKLE, PH_HASH: begin
          bif_d = bif_q + 6'd1;
          if (bif_d >= 6'(HashBytes)) begin
            bif_d = '0; adv = 1'b1;
          end
        end
        PH_ISCR, PH_OSCR, PH_WBYTE: begin
          bif_d = bif_q + 6'd1;
          scr_d = scr_dec;
          if (scr_dec == '0) begin
            bif_d = '0; adv = 1'b1;
          end
        end
        PH_TXCOUNT, PH_INCOUNT, PH_ISCRLEN, PH_OUTCOUNT, PH_OSCRLEN, PH_WCOUNT,
        PH_WLEN: begin
          if (bif_q == '0) begin
            if (b < TagU16) begin
              sdone = 1'b1; sval = {56'd0, b};
            end else begin
              tag_d = b; acc_d = '0; bif_d = 6'd1;
            end
          end else begin
            sval = acc_q | ({56'd0, b} << {bif1[2:0], 3'b000});
            acc_d = sval;
            bif_d = bif_q + 6'd1;
            if ((need == 3'd0) ? (bif_q[3:0] == 4'd8) : (bif_q[2:0] == need)) begin
              sdone = 1'b1; acc_d = '0; bif_d = '0;
              if (tag_q == TagU16) begin
                if (sval < 64'(TagU16)) st_d = ST_NONCANON;
              end else if (tag_q == TagU32) begin
                if (sval < MinU32Form) st_d = ST_NONCANON;
              end else if (sval < MinU64Form) st_d = ST_NONCANON;
              else if (sval > MaxSize) st_d = ST_LIMIT;
              if (st_d == ST_OK && sval > CountMax) st_d = ST_LIMIT;
            end
          end
          if (sdone) begin
            comp = 1'b1; val = sval;
            adv = (st_d == ST_OK);
          end
        end
        default: begin
          sval = acc_q | ({56'd0, b} << {bif_q[2:0], 3'b000});
          acc_d = sval;
          bif_d = bif_q + 6'd1;
          if ((ph_q == PH_AMOUNT) ? (bif_q == 6'd7) :
              (ph_q == PH_FLAG) ? 1'b1 : (bif_q == 6'd3)) begin
            comp = 1'b1; val = sval; acc_d = '0; bif_d = '0; adv = 1'b1;
          end
        end
      endcase
      c = val[CountBits-1:0];
      if (adv) begin
        case (ph_q)
          PH_BVER:   ph_d = PH_PREV;
          PH_PREV:   ph_d = PH_MERKLE;
          PH_MERKLE: ph_d = PH_TIME;
          PH_TIME:   ph_d = PH_BITS;
          PH_BITS:   ph_d = PH_NONCE;
          PH_NONCE: begin
            if (mode_i == ModeHeader) begin
              ph_d = PH_DONE; done_d = 1'b1;
            end else ph_d = PH_TXCOUNT;
          end
          PH_TXCOUNT: begin
            txr_d = c;
            if (c == '0) begin
              ph_d = PH_DONE; done_d = 1'b1;
            end else begin
              ph_d = PH_TXVER; sw_d = 1'b0; aw_d = 1'b0;
            end
          end
          PH_TXVER: ph_d = PH_INCOUNT;
          PH_INCOUNT: begin
            if (c == '0 && !sw_q) ph_d = PH_FLAG;
            else begin
              intot_d = c; inr_d = c;
              ph_d = (c == '0) ? PH_OUTCOUNT : PH_HASH;
            end
          end
          PH_FLAG: begin
            if (val == {56'd0, SegwitFlag}) begin
              sw_d = 1'b1; ph_d = PH_INCOUNT;
            end else if (val == '0) st_d = ST_NOWITNESS;
            else st_d = ST_BADFLAG;
          end
          PH_HASH:  ph_d = PH_INDEX;
          PH_INDEX: ph_d = PH_ISCRLEN;
          PH_ISCRLEN: begin
            scr_d = c;
            ph_d = (c == '0) ? PH_SEQ : PH_ISCR;
          end
          PH_ISCR: ph_d = PH_SEQ;
          PH_SEQ: begin
            inr_d = inr_dec;
            ph_d = (inr_dec != '0) ? PH_HASH : PH_OUTCOUNT;
          end
          PH_OUTCOUNT, PH_OSCRLEN, PH_OSCR: begin
            // output count zero or last output done ends the outputs
            if (ph_q == PH_OUTCOUNT) outr_d = c;
            if (ph_q == PH_OSCRLEN) scr_d = c;
            if (ph_q == PH_OUTCOUNT && c != '0) ph_d = PH_AMOUNT;
            else if (ph_q == PH_OSCRLEN && c != '0) ph_d = PH_OSCR;
            else if (ph_q != PH_OUTCOUNT && outr_dec != '0) begin
              outr_d = outr_dec; ph_d = PH_AMOUNT;
            end else begin
              if (ph_q != PH_OUTCOUNT) outr_d = outr_dec;
              if (!sw_q) ph_d = PH_LOCK;
              else begin
                inr_d = intot_q;
                if (intot_q != '0) ph_d = PH_WCOUNT;
                else if (!aw_q) st_d = ST_NOWITNESS;
                else ph_d = PH_LOCK;
              end
            end
          end
          PH_AMOUNT: ph_d = PH_OSCRLEN;
          PH_WCOUNT, PH_WLEN, PH_WBYTE: begin
            if (ph_q == PH_WCOUNT) begin
              wir_d = c;
              if (c != '0) aw_d = 1'b1;
            end
            if (ph_q == PH_WLEN) scr_d = c;
            if (ph_q == PH_WCOUNT && c != '0) ph_d = PH_WLEN;
            else if (ph_q == PH_WLEN && c != '0) ph_d = PH_WBYTE;
            else if (ph_q != PH_WCOUNT && wir_dec != '0) begin
              wir_d = wir_dec; ph_d = PH_WLEN;
            end else begin
              if (ph_q != PH_WCOUNT) wir_d = wir_dec;
              inr_d = inr_dec;
              if (inr_dec != '0) ph_d = PH_WCOUNT;
              else if (!aw_d) st_d = ST_NOWITNESS;
              else ph_d = PH_LOCK;
            end
          end
          PH_LOCK: begin
            if (is_tx) begin
              ph_d = PH_DONE; done_d = 1'b1;
            end else begin
              txr_d = txr_q - 1'b1;
              if (txr_d != '0) begin
                ph_d = PH_TXVER; sw_d = 1'b0; aw_d = 1'b0;
              end else begin
                ph_d = PH_DONE; done_d = 1'b1;
              end
            end
          end
          default: begin
            ph_d = PH_DONE; done_d = 1'b1;
          end
        endcase
      end
    end
    fst = st_d;
    if (beat_i.final_byte && st_d == ST_OK) fst = done_d ? ST_ACCEPTED : ST_TRUNCATED;
    beat_o.field_value = val;
    beat_o.field_complete = comp;
    beat_o.status = fst;
    beat_o.message_end = beat_i.final_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_BVER; bif_q <= '0; acc_q <= '0; tag_q <= '0;
      txr_q <= '0; inr_q <= '0; intot_q <= '0; outr_q <= '0; scr_q <= '0; wir_q <= '0;
      sw_q <= 1'b0; aw_q <= 1'b0; done_q <= 1'b0; st_q <= ST_OK;
    end else if (restart_i || (step_i && beat_i.final_byte)) begin
      ph_q <= first_ph; bif_q <= '0; acc_q <= '0; tag_q <= '0;
      txr_q <= '0; inr_q <= '0; intot_q <= '0; outr_q <= '0; scr_q <= '0; wir_q <= '0;
      sw_q <= 1'b0; aw_q <= 1'b0; done_q <= 1'b0; st_q <= ST_OK;
    end else if (step_i) begin
      ph_q <= ph_d; bif_q <= bif_d; acc_q <= acc_d; tag_q <= tag_d;
      txr_q <= txr_d; inr_q <= inr_d; intot_q <= intot_d; outr_q <= outr_d;
      scr_q <= scr_d; wir_q <= wir_d; sw_q <= sw_d; aw_q <= aw_d; done_q <= done_d;
      st_q <= st_d;
    end
  end
endmodule

// ===== rtl/core/block_tx_wire_format_parser.sv =====
// top level: serialized block/header/transaction byte stream checker
// One byte is taken per cycle while in_stall_o is low and gives one result beat; the
// parse state is computed combinationally from the input beat and registered, so full
// rate is one byte per clock while the output is not stalled. An output register with a
// skid stage keeps the input open while a result waits. The message_mode register
// (address 0) selects full block, header only or single transaction; writing it restarts.
module block_tx_wire_format_parser import btwfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o
);
  logic [1:0] mode;
  logic       restart, take;
  out_beat_t  res;
  logic       ov_q, ov_d, sv_q, sv_d;
  out_beat_t  od_q, od_d, sd_q, sd_d;

  btwfp_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mode_o(mode), .restart_o(restart)
  );

  assign in_stall_o = sv_q;
  assign take = in_valid_i && !sv_q;

  btwfp_core u_core (
    .clk_i, .rst_ni, .mode_i(mode), .restart_i(restart), .step_i(take),
    .beat_i(in_data_i), .beat_o(res)
  );

  always_comb begin
    ov_d = ov_q; od_d = od_q; sv_d = sv_q; sd_d = sd_q;
    if (!ov_q || !out_stall_i) begin
      if (sv_q) begin
        ov_d = 1'b1; od_d = sd_q; sv_d = 1'b0;
      end else begin
        ov_d = take; od_d = res;
      end
    end else if (take) begin
      sv_d = 1'b1; sd_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d; sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d; sd_q <= sd_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;
endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the block/tx wire format parser: byte stream stimulus, predictor, scoreboard
module testbench;
  import btwfp_pkg::*;

  localparam logic [1:0] ModeAddr   = 2'd0;
  localparam int         CycleLimit = 400000;
  localparam int         HoldCycles = 300;

  class parse_scoreboard;
    logic [1:0]  mode;
    phase_e      phase;
    logic [5:0]  pos;
    logic [63:0] acc;
    logic [7:0]  tag;
    logic [31:0] tx_left, in_left, in_total, out_left, pay_left, items_left;
    bit          segwit, saw_wit, done;
    status_e     sticky;
    out_beat_t   expected_q[$];
    int          errors;

    function new();
      mode   = ModeBlock;
      errors = 0;
      restart();
    endfunction

    function logic [4:0] kind_for(phase_e ph);
      case (ph)
        PH_OSCRLEN: return 5'd12;
        PH_OSCR:    return 5'd13;
        PH_WCOUNT:  return 5'd17;
        PH_WLEN:    return 5'd18;
        PH_WBYTE:   return 5'd19;
        PH_LOCK:    return 5'd20;
        PH_DONE:    return KindIgnored;
        default:    return 5'(ph);
      endcase
    endfunction

    function void go_done();
      phase = PH_DONE;
      done  = 1'b1;
    endfunction

    function void start_tx();
      phase   = PH_TXVER;
      segwit  = 1'b0;
      saw_wit = 1'b0;
    endfunction

    function void restart();
      pos = '0; acc = '0; tag = '0;
      tx_left = '0; in_left = '0; in_total = '0;
      out_left = '0; pay_left = '0; items_left = '0;
      segwit = 1'b0; saw_wit = 1'b0; sticky = ST_OK; done = 1'b0;
      if (mode >= 2) start_tx();
      else phase = PH_BVER;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
      restart();
    endfunction

    function void witness_check();
      if (!saw_wit) sticky = ST_NOWITNESS;
      else phase = PH_LOCK;
    endfunction

    function void next_stack();
      in_left--;
      if (in_left > 0) phase = PH_WCOUNT;
      else witness_check();
    endfunction

    function void next_item();
      items_left--;
      if (items_left > 0) phase = PH_WLEN;
      else next_stack();
    endfunction

    function void end_outputs();
      if (!segwit) begin
        phase = PH_LOCK;
        return;
      end
      in_left = in_total;
      if (in_left > 0) phase = PH_WCOUNT;
      else witness_check();
    endfunction

    function void next_output();
      out_left--;
      if (out_left > 0) phase = PH_AMOUNT;
      else end_outputs();
    endfunction

    function void advance(phase_e ph, logic [63:0] v);
      logic [31:0] c;
      c = v[31:0];
      case (ph)
        PH_BVER:   phase = PH_PREV;
        PH_PREV:   phase = PH_MERKLE;
        PH_MERKLE: phase = PH_TIME;
        PH_TIME:   phase = PH_BITS;
        PH_BITS:   phase = PH_NONCE;
        PH_NONCE:  if (mode == ModeHeader) go_done(); else phase = PH_TXCOUNT;
        PH_TXCOUNT: begin
          tx_left = c;
          if (c == 0) go_done(); else start_tx();
        end
        PH_TXVER:  phase = PH_INCOUNT;
        PH_INCOUNT: begin
          if (c == 0 && !segwit) phase = PH_FLAG;
          else begin
            in_total = c;
            in_left  = c;
            phase    = (c == 0) ? PH_OUTCOUNT : PH_HASH;
          end
        end
        PH_FLAG: begin
          if (v == 64'(SegwitFlag)) begin
            segwit = 1'b1;
            phase  = PH_INCOUNT;
          end else if (v == 0) sticky = ST_NOWITNESS;
          else sticky = ST_BADFLAG;
        end
        PH_HASH:  phase = PH_INDEX;
        PH_INDEX: phase = PH_ISCRLEN;
        PH_ISCRLEN: begin
          pay_left = c;
          phase    = (c == 0) ? PH_SEQ : PH_ISCR;
        end
        PH_ISCR: phase = PH_SEQ;
        PH_SEQ: begin
          in_left--;
          phase = (in_left > 0) ? PH_HASH : PH_OUTCOUNT;
        end
        PH_OUTCOUNT: begin
          out_left = c;
          if (c == 0) end_outputs(); else phase = PH_AMOUNT;
        end
        PH_AMOUNT: phase = PH_OSCRLEN;
        PH_OSCRLEN: begin
          pay_left = c;
          if (c == 0) next_output(); else phase = PH_OSCR;
        end
        PH_OSCR: next_output();
        PH_WCOUNT: begin
          items_left = c;
          if (c > 0) saw_wit = 1'b1;
          if (c == 0) next_stack(); else phase = PH_WLEN;
        end
        PH_WLEN: begin
          pay_left = c;
          if (c == 0) next_item(); else phase = PH_WBYTE;
        end
        PH_WBYTE: next_item();
        PH_LOCK: begin
          if (mode >= 2) go_done();
          else begin
            tx_left--;
            if (tx_left > 0) start_tx(); else go_done();
          end
        end
        default: go_done();
      endcase
    endfunction

    function bit size_byte(input logic [7:0] b, output logic [63:0] v);
      int need;
      v = '0;
      if (pos == 0) begin
        if (b < TagU16) begin
          v = 64'(b);
          return 1'b1;
        end
        tag = b;
        acc = '0;
        pos = 6'd1;
        return 1'b0;
      end
      acc = acc | (64'(b) << (8 * ((pos - 6'd1) & 6'd7)));
      pos = pos + 6'd1;
      need = (tag == TagU16) ? 2 : (tag == TagU32) ? 4 : 8;
      if (int'(pos) - 1 < need) return 1'b0;
      v   = acc;
      acc = '0;
      pos = '0;
      if (tag == TagU16) begin
        if (v < 64'(TagU16)) sticky = ST_NONCANON;
      end else if (tag == TagU32) begin
        if (v < MinU32Form) sticky = ST_NONCANON;
      end else begin
        if (v < MinU64Form) sticky = ST_NONCANON;
        else if (v > MaxSize) sticky = ST_LIMIT;
      end
      if (sticky == ST_OK && v > CountMax) sticky = ST_LIMIT;
      return 1'b1;
    endfunction

    function void note_byte(in_beat_t beat);
      out_beat_t   e;
      phase_e      ph;
      logic [63:0] v;
      int          len;
      e = '0;
      e.field_kind = KindIgnored;
      ph = phase;
      v  = '0;
      if (sticky != ST_OK) begin
      end else if (ph == PH_DONE) begin
        sticky = ST_TRAILING;
      end else begin
        e.field_kind       = kind_for(ph);
        e.field_byte_index = pos[4:0];
        case (ph)
          PH_PREV, PH_MERKLE, PH_HASH: begin
            pos = pos + 6'd1;
            if (pos >= HashBytes) begin
              pos = '0;
              advance(ph, '0);
            end
          end
          PH_ISCR, PH_OSCR, PH_WBYTE: begin
            pos = pos + 6'd1;
            pay_left--;
            if (pay_left == 0) begin
              pos = '0;
              advance(ph, '0);
            end
          end
          PH_TXCOUNT, PH_INCOUNT, PH_ISCRLEN, PH_OUTCOUNT,
          PH_OSCRLEN, PH_WCOUNT, PH_WLEN: begin
            if (size_byte(beat.data_byte, v)) begin
              e.field_complete = 1'b1;
              e.field_value    = v;
              if (sticky == ST_OK) advance(ph, v);
            end
          end
          default: begin
            len = (ph == PH_AMOUNT) ? 8 : (ph == PH_FLAG) ? 1 : 4;
            acc = acc | (64'(beat.data_byte) << (8 * (pos & 6'd7)));
            pos = pos + 6'd1;
            if (pos >= len) begin
              e.field_complete = 1'b1;
              e.field_value    = acc;
              v   = acc;
              acc = '0;
              pos = '0;
              advance(ph, v);
            end
          end
        endcase
      end
      e.status = sticky;
      if (beat.final_byte && sticky == ST_OK) e.status = done ? ST_ACCEPTED : ST_TRUNCATED;
      e.message_end = beat.final_byte;
      expected_q = {expected_q, e};
      if (beat.final_byte) restart();
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.field_kind !== e.field_kind || got.field_byte_index !== e.field_byte_index ||
          got.field_value !== e.field_value || got.field_complete !== e.field_complete ||
          got.status !== e.status || got.message_end !== e.message_end) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: kind %0d/%0d idx %0d/%0d val %h/%h comp %0b/%0b st %0d/%0d end %0b/%0b",
                   e.field_kind, got.field_kind, e.field_byte_index, got.field_byte_index,
                   e.field_value, got.field_value, e.field_complete, got.field_complete,
                   e.status, got.status, e.message_end, got.message_end);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_beat_t   out_data_o;

  parse_scoreboard sb = new();
  logic [7:0] msg_q[$];
  int tx_idle_pct, rx_idle_pct, hold_left, bytes_sent, cycles;
  bit hold_req;

  block_tx_wire_format_parser i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_beat(logic [7:0] b, logic fin);
    in_beat_t beat;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    beat.data_byte  = b;
    beat.final_byte = fin;
    in_valid_i = 1'b1;
    in_data_i  = beat;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(beat);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) send_beat(msg_q[i], i == msg_q.size() - 1);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] m);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = ModeAddr; pwdata = 32'(m);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_mode(m);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic void add_byte(logic [7:0] b);
    msg_q = {msg_q, b};
  endfunction

  function automatic void put_int(longint unsigned v, int n);
    for (int i = 0; i < n; i++) add_byte(8'(v >> (8 * i)));
  endfunction

  function automatic void put_rand(int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom));
  endfunction

  function automatic void put_size(int unsigned v);
    if (v < 253) add_byte(8'(v));
    else if (v <= 32'hFFFF) begin
      add_byte(TagU16);
      put_int(v, 2);
    end else begin
      add_byte(TagU32);
      put_int(v, 4);
    end
  endfunction

  function automatic void put_payload();
    int unsigned n;
    n = ($urandom_range(19) == 0) ? $urandom_range(253, 300) : $urandom_range(0, 6);
    put_size(n);
    put_rand(n);
  endfunction

  function automatic void put_tx();
    bit segw;
    int nin, nout, nitems;
    segw = ($urandom_range(2) == 0);
    put_rand(4);
    if (segw) begin
      add_byte(8'h00);
      add_byte(SegwitFlag);
    end
    nin = segw ? $urandom_range(0, 2) : $urandom_range(1, 2);
    if (segw && $urandom_range(4) != 0 && nin == 0) nin = 1;
    put_size(nin);
    for (int i = 0; i < nin; i++) begin
      put_rand(36);
      put_payload();
      put_rand(4);
    end
    nout = $urandom_range(0, 2);
    put_size(nout);
    for (int i = 0; i < nout; i++) begin
      put_rand(8);
      put_payload();
    end
    if (segw) begin
      for (int i = 0; i < nin; i++) begin
        nitems = $urandom_range(0, 2);
        put_size(nitems);
        for (int k = 0; k < nitems; k++) begin
          put_size($urandom_range(0, 4));
          put_rand(msg_q[$]);
        end
      end
    end
    put_rand(4);
  endfunction

  function automatic void build_msg(logic [1:0] m);
    int ntx, r, p;
    msg_q.delete();
    if (m < 2) begin
      put_rand(80);
      if (m == ModeBlock) begin
        ntx = $urandom_range(0, 1);
        put_size(ntx);
        for (int i = 0; i < ntx; i++) put_tx();
      end
    end else begin
      put_tx();
    end
    r = $urandom_range(0, 9);
    p = $urandom_range(0, msg_q.size() - 1);
    case (r)
      0: msg_q[p] = 8'($urandom);
      1: while (msg_q.size() > p + 1) void'(msg_q.pop_back());
      2: put_rand($urandom_range(1, 3));
      3: begin
        msg_q.delete();
        put_rand($urandom_range(1, 20));
      end
      default: ;
    endcase
  endfunction

  task automatic directed();
    write_mode(2'd2);
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h05, 8'h00};
    send_msg();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h00, 8'h01, 8'h00, 8'h00};
    send_msg();
    msg_q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00};
    send_msg();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
              8'h00, 8'h00, 8'h00};
    send_msg();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_msg();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02};
    send_msg();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    send_msg();
    msg_q = '{8'hFF, 8'h00};
    send_msg();
    wait_drain();
  endtask

  initial begin
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    cycles      = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed();
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 72 : 0;
      rx_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 37 : 0;
      for (int m = 0; m < 4; m++) begin
        wait_drain();
        write_mode(2'(m));
        if (ph == 2 && m == 0) hold_req = 1'b1;
        bytes_sent = 0;
        while (bytes_sent < 40) begin
          build_msg(2'(m));
          send_msg();
        end
      end
    end
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
